/* hdl/lwep_pkg.sv */
// shared types and constants for the lwe phase decrypt block
package lwep_pkg;

  localparam int unsigned QW = 63;
  localparam int unsigned TW = 16;

  localparam logic [QW-1:0] CIPHER_RESET  = 63'd4294967296;
  localparam logic [TW-1:0] PLAIN_RESET   = 16'd4;
  localparam logic [TW-1:0] DEFAULT_PLAIN = 16'd4;

  // key coefficient codes, two's complement
  localparam logic [1:0] KEY_ZERO = 2'b00;
  localparam logic [1:0] KEY_POS  = 2'b01;
  localparam logic [1:0] KEY_NEG2 = 2'b10;
  localparam logic [1:0] KEY_NEG  = 2'b11;

  // register index as decoded from the address
  localparam logic REG_CIPHER = 1'b0;
  localparam logic REG_PLAIN  = 1'b1;

  typedef struct packed {
    logic [QW-1:0] mask;
    logic [1:0]    key;
    logic [QW-1:0] body;
    logic          last;
    logic          mask_ok;
    logic          body_ok;
  } item_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_PREP,
    ST_RED,
    ST_ARITH,
    ST_NEG2,
    ST_PHASE,
    ST_SCALE,
    ST_ROUND,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    DST_ACC,
    DST_MASK,
    DST_BODY
  } red_dst_t;

endpackage

/* hdl/lwe_phase_decrypt_core.sv */
// top level of the lwe phase decrypt block: register port and module wiring
//
//   channel   signals                                          direction
//   input     push, full, mask_coeff, key_coeff, body_value,   in
//             last_coeff
//   result    empty, pop, plain_value                          out
//   config    psel, penable, pwrite, paddr, pwdata, prdata,    in/out
//             pready
//
// an in-range coefficient with key 0, +1 or -1 that is not last is accumulated straight from the queue head.
// each reduction of an out-of-range mask, body or stale accumulator goes through
// the shared bit-serial reducer; a last item then passes through phase, the
// bit-serial scaling by t and rounding.
// reset clears the accumulator, the queue and the result register.
// a pending result stalls only the back end; the input queue keeps taking items until full.
module lwe_phase_decrypt_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [lwep_pkg::QW-1:0]    mask_coeff,
  input  logic signed [1:0]          key_coeff,
  input  logic [lwep_pkg::QW-1:0]    body_value,
  input  logic                       last_coeff,
  output logic                       empty,
  input  logic                       pop,
  output logic [lwep_pkg::TW-1:0]    plain_value,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready
);

  logic [lwep_pkg::QW-1:0] cipher_modulus;
  logic [lwep_pkg::TW-1:0] plain_modulus;
  logic                    wr_en;
  logic                    q_write;

  lwep_pkg::item_t         head;
  logic                    head_valid;
  logic                    head_pop;
  logic                    red_start;
  logic [lwep_pkg::QW-1:0] red_value;
  logic                    red_done;
  logic [lwep_pkg::QW-1:0] red_result;
  lwep_pkg::back_state_t   back_state;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign q_write = wr_en && (paddr[3] == lwep_pkg::REG_CIPHER);

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_modulus <= lwep_pkg::CIPHER_RESET;
      plain_modulus  <= lwep_pkg::PLAIN_RESET;
    end else if (wr_en) begin
      if (paddr[3] == lwep_pkg::REG_CIPHER) begin
        cipher_modulus <= pwdata[lwep_pkg::QW-1:0];
      end else begin
        plain_modulus <= pwdata[lwep_pkg::TW-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == lwep_pkg::REG_CIPHER) begin
      prdata = {1'b0, cipher_modulus};
    end else begin
      prdata = {48'd0, plain_modulus};
    end
  end

  lwep_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .mask_coeff     (mask_coeff),
    .key_coeff      (key_coeff),
    .body_value     (body_value),
    .last_coeff     (last_coeff),
    .cipher_modulus (cipher_modulus),
    .head           (head),
    .head_valid     (head_valid),
    .head_pop       (head_pop)
  );

  lwep_modred u_modred (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .value   (red_value),
    .modulus (cipher_modulus),
    .done    (red_done),
    .result  (red_result)
  );

  lwep_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cipher_modulus (cipher_modulus),
    .plain_modulus  (plain_modulus),
    .q_write        (q_write),
    .head           (head),
    .head_valid     (head_valid),
    .head_pop       (head_pop),
    .red_start      (red_start),
    .red_value      (red_value),
    .red_done       (red_done),
    .red_result     (red_result),
    .empty          (empty),
    .pop            (pop),
    .plain_value    (plain_value),
    .back_state     (back_state)
  );

  // queue and result register come out of reset empty
  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue or result register not clear after reset");

  // a result only shows up from the output step or the small-modulus path
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> ($past(back_state) == lwep_pkg::ST_OUT ||
                      $past(back_state) == lwep_pkg::ST_RUN))
    else $error("result appeared from an unexpected back end state");

  // the reducer finishes only while the back end waits for it
  a_red_done_wait: assert property (@(posedge clk) disable iff (rst)
    red_done |-> back_state == lwep_pkg::ST_RED)
    else $error("reduction finished while back end not waiting");

endmodule

/* hdl/lwep_modred.sv */
// iterative reduction of a 63-bit value modulo q, one bit per cycle
module lwep_modred (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lwep_pkg::QW-1:0]    value,
  input  logic [lwep_pkg::QW-1:0]    modulus,
  output logic                       done,
  output logic [lwep_pkg::QW-1:0]    result
);

  logic                    busy;
  logic [5:0]              cnt;
  logic [lwep_pkg::QW-1:0] shreg;
  logic [lwep_pkg::QW-1:0] rem;
  logic [lwep_pkg::QW:0]   trial;
  logic                    ge;

  assign trial  = {rem, shreg[lwep_pkg::QW-1]};
  assign ge     = trial >= {1'b0, modulus};
  assign result = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(lwep_pkg::QW - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= value;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[lwep_pkg::QW-2:0], 1'b0};
      // trial < 2q, so one subtract brings it below q
      rem   <= ge ? lwep_pkg::QW'(trial - {1'b0, modulus}) : trial[lwep_pkg::QW-1:0];
    end
  end

endmodule

/* hdl/lwep_front.sv */
// input side: range classification of each item and the queue to the back end
module lwep_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic [lwep_pkg::QW-1:0]     mask_coeff,
  input  logic signed [1:0]           key_coeff,
  input  logic [lwep_pkg::QW-1:0]     body_value,
  input  logic                        last_coeff,
  input  logic [lwep_pkg::QW-1:0]     cipher_modulus,
  output lwep_pkg::item_t             head,
  output logic                        head_valid,
  input  logic                        head_pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  lwep_pkg::item_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            accept;
  logic            take;
  lwep_pkg::item_t entry;

  assign full       = count == CW'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];
  assign accept     = push && !full;
  assign take       = head_pop && head_valid;

  always_comb begin
    entry.mask    = mask_coeff;
    entry.key     = $unsigned(key_coeff);
    entry.body    = body_value;
    entry.last    = last_coeff;
    entry.mask_ok = mask_coeff < cipher_modulus;
    entry.body_ok = body_value < cipher_modulus;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (accept && !take) begin
        count <= count + CW'(1);
      end else if (take && !accept) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

/* hdl/lwep_back.sv */
// back end: modular accumulation, phase, scaling by t, rounding and the result register
module lwep_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lwep_pkg::QW-1:0]     cipher_modulus,
  input  logic [lwep_pkg::TW-1:0]     plain_modulus,
  input  logic                        q_write,
  input  lwep_pkg::item_t             head,
  input  logic                        head_valid,
  output logic                        head_pop,
  output logic                        red_start,
  output logic [lwep_pkg::QW-1:0]     red_value,
  input  logic                        red_done,
  input  logic [lwep_pkg::QW-1:0]     red_result,
  output logic                        empty,
  input  logic                        pop,
  output logic [lwep_pkg::TW-1:0]     plain_value,
  output lwep_pkg::back_state_t       back_state
);

  function automatic logic [lwep_pkg::QW-1:0] add_mod(input logic [lwep_pkg::QW-1:0] x,
                                                     input logic [lwep_pkg::QW-1:0] y,
                                                     input logic [lwep_pkg::QW-1:0] m);
    logic [lwep_pkg::QW:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[lwep_pkg::QW-1:0];
  endfunction

  function automatic logic [lwep_pkg::QW-1:0] sub_mod(input logic [lwep_pkg::QW-1:0] x,
                                                     input logic [lwep_pkg::QW-1:0] y,
                                                     input logic [lwep_pkg::QW-1:0] m);
    logic [lwep_pkg::QW:0] d;
    if (x >= y) begin
      d = {1'b0, x} - {1'b0, y};
    end else begin
      d = {1'b0, x} + {1'b0, m} - {1'b0, y};
    end
    return d[lwep_pkg::QW-1:0];
  endfunction

  lwep_pkg::back_state_t state, state_next;
  lwep_pkg::red_dst_t    dst, dst_next;

  logic [lwep_pkg::QW-1:0] acc, acc_next;
  logic                    acc_ok, acc_ok_next;
  logic [lwep_pkg::QW-1:0] w_mask, w_mask_next;
  logic [lwep_pkg::QW-1:0] w_body, w_body_next;
  logic [1:0]              w_key, w_key_next;
  logic                    w_last, w_last_next;
  logic                    w_mask_ok, w_mask_ok_next;
  logic                    w_body_ok, w_body_ok_next;
  logic [lwep_pkg::QW-1:0] rem, rem_next;
  logic [lwep_pkg::TW-1:0] quo, quo_next;
  logic [3:0]              bit_idx, bit_idx_next;
  logic                    half, half_next;
  logic                    out_valid, out_valid_next;
  logic [lwep_pkg::TW-1:0] out_data, out_data_next;

  logic                    q_small;
  logic [lwep_pkg::TW-1:0] t_eff;
  logic                    slot_free;
  logic [lwep_pkg::QW-1:0] acc_fast;
  logic [lwep_pkg::QW:0]   r_dbl;
  logic [lwep_pkg::QW:0]   r_add;
  logic [lwep_pkg::QW:0]   r_rnd;

  assign q_small     = cipher_modulus[lwep_pkg::QW-1:1] == '0;
  assign t_eff       = (plain_modulus == '0) ? lwep_pkg::DEFAULT_PLAIN : plain_modulus;
  assign slot_free   = !out_valid || pop;
  assign empty       = !out_valid;
  assign plain_value = out_data;
  assign back_state  = state;

  assign r_dbl = {rem, 1'b0};
  assign r_add = {1'b0, rem} + {1'b0, w_body};
  assign r_rnd = {1'b0, rem} + {2'b00, cipher_modulus[lwep_pkg::QW-1:1]};

  always_comb begin
    case (head.key)
      lwep_pkg::KEY_POS: acc_fast = add_mod(acc, head.mask, cipher_modulus);
      lwep_pkg::KEY_NEG: acc_fast = sub_mod(acc, head.mask, cipher_modulus);
      default:           acc_fast = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwep_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    dst_next       = dst;
    acc_next       = acc;
    acc_ok_next    = acc_ok;
    w_mask_next    = w_mask;
    w_body_next    = w_body;
    w_key_next     = w_key;
    w_last_next    = w_last;
    w_mask_ok_next = w_mask_ok;
    w_body_ok_next = w_body_ok;
    rem_next       = rem;
    quo_next       = quo;
    bit_idx_next   = bit_idx;
    half_next      = half;
    out_valid_next = out_valid && !pop;
    out_data_next  = out_data;
    head_pop       = 1'b0;
    red_start      = 1'b0;
    red_value      = acc;

    case (state)
      lwep_pkg::ST_RUN: begin
        if (head_valid) begin
          if (q_small) begin
            // every reduction gives zero, so the result is zero too
            if (!head.last) begin
              head_pop = 1'b1;
              acc_next = '0;
            end else if (slot_free) begin
              head_pop       = 1'b1;
              acc_next       = '0;
              out_valid_next = 1'b1;
              out_data_next  = '0;
            end
          end else if (acc_ok && head.mask_ok && !head.last && head.key != lwep_pkg::KEY_NEG2) begin
            head_pop = 1'b1;
            acc_next = acc_fast;
          end else begin
            head_pop       = 1'b1;
            w_mask_next    = head.mask;
            w_body_next    = head.body;
            w_key_next     = head.key;
            w_last_next    = head.last;
            w_mask_ok_next = head.mask_ok;
            w_body_ok_next = head.body_ok;
            state_next     = lwep_pkg::ST_PREP;
          end
        end
      end
      lwep_pkg::ST_PREP: begin
        if (!acc_ok) begin
          red_start  = 1'b1;
          red_value  = acc;
          dst_next   = lwep_pkg::DST_ACC;
          state_next = lwep_pkg::ST_RED;
        end else if (!w_mask_ok) begin
          red_start  = 1'b1;
          red_value  = w_mask;
          dst_next   = lwep_pkg::DST_MASK;
          state_next = lwep_pkg::ST_RED;
        end else if (w_last && !w_body_ok) begin
          red_start  = 1'b1;
          red_value  = w_body;
          dst_next   = lwep_pkg::DST_BODY;
          state_next = lwep_pkg::ST_RED;
        end else begin
          state_next = lwep_pkg::ST_ARITH;
        end
      end
      lwep_pkg::ST_RED: begin
        if (red_done) begin
          case (dst)
            lwep_pkg::DST_ACC: begin
              acc_next    = red_result;
              acc_ok_next = 1'b1;
            end
            lwep_pkg::DST_MASK: begin
              w_mask_next    = red_result;
              w_mask_ok_next = 1'b1;
            end
            lwep_pkg::DST_BODY: begin
              w_body_next    = red_result;
              w_body_ok_next = 1'b1;
            end
            default: begin
            end
          endcase
          state_next = lwep_pkg::ST_PREP;
        end
      end
      lwep_pkg::ST_ARITH: begin
        case (w_key)
          lwep_pkg::KEY_POS:  acc_next = add_mod(acc, w_mask, cipher_modulus);
          lwep_pkg::KEY_NEG,
          lwep_pkg::KEY_NEG2: acc_next = sub_mod(acc, w_mask, cipher_modulus);
          default:            acc_next = acc;
        endcase
        if (w_key == lwep_pkg::KEY_NEG2) begin
          state_next = lwep_pkg::ST_NEG2;
        end else if (w_last) begin
          state_next = lwep_pkg::ST_PHASE;
        end else begin
          state_next = lwep_pkg::ST_RUN;
        end
      end
      lwep_pkg::ST_NEG2: begin
        // second subtraction for the out-of-range key of minus two
        acc_next   = sub_mod(acc, w_mask, cipher_modulus);
        state_next = w_last ? lwep_pkg::ST_PHASE : lwep_pkg::ST_RUN;
      end
      lwep_pkg::ST_PHASE: begin
        // phase kept in w_body from here on
        w_body_next  = sub_mod(w_body, acc, cipher_modulus);
        acc_next     = '0;
        acc_ok_next  = 1'b1;
        rem_next     = '0;
        quo_next     = '0;
        bit_idx_next = 4'(lwep_pkg::TW - 1);
        half_next    = 1'b0;
        state_next   = lwep_pkg::ST_SCALE;
      end
      lwep_pkg::ST_SCALE: begin
        // long division of phase*t by q, msb of t first, a doubling step then an add step per bit
        if (!half) begin
          if (r_dbl >= {1'b0, cipher_modulus}) begin
            rem_next = lwep_pkg::QW'(r_dbl - {1'b0, cipher_modulus});
            quo_next = {quo[lwep_pkg::TW-2:0], 1'b1};
          end else begin
            rem_next = r_dbl[lwep_pkg::QW-1:0];
            quo_next = {quo[lwep_pkg::TW-2:0], 1'b0};
          end
          half_next = 1'b1;
        end else begin
          if (t_eff[bit_idx]) begin
            if (r_add >= {1'b0, cipher_modulus}) begin
              rem_next = lwep_pkg::QW'(r_add - {1'b0, cipher_modulus});
              quo_next = quo + lwep_pkg::TW'(1);
            end else begin
              rem_next = r_add[lwep_pkg::QW-1:0];
            end
          end
          half_next = 1'b0;
          if (bit_idx == '0) begin
            state_next = lwep_pkg::ST_ROUND;
          end else begin
            bit_idx_next = bit_idx - 4'd1;
          end
        end
      end
      lwep_pkg::ST_ROUND: begin
        if (r_rnd >= {1'b0, cipher_modulus}) begin
          quo_next = quo + lwep_pkg::TW'(1);
        end
        state_next = lwep_pkg::ST_OUT;
      end
      lwep_pkg::ST_OUT: begin
        if (slot_free) begin
          out_valid_next = 1'b1;
          // rounding up to t wraps to zero
          out_data_next  = (quo == t_eff) ? '0 : quo;
          state_next     = lwep_pkg::ST_RUN;
        end
      end
      default: begin
        state_next = lwep_pkg::ST_RUN;
      end
    endcase

    if (q_write) begin
      acc_ok_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      acc_ok    <= 1'b1;
      out_valid <= 1'b0;
      dst       <= lwep_pkg::DST_ACC;
      half      <= 1'b0;
      bit_idx   <= '0;
    end else begin
      acc       <= acc_next;
      acc_ok    <= acc_ok_next;
      out_valid <= out_valid_next;
      dst       <= dst_next;
      half      <= half_next;
      bit_idx   <= bit_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    w_mask    <= w_mask_next;
    w_body    <= w_body_next;
    w_key     <= w_key_next;
    w_last    <= w_last_next;
    w_mask_ok <= w_mask_ok_next;
    w_body_ok <= w_body_ok_next;
    rem       <= rem_next;
    quo       <= quo_next;
    out_data  <= out_data_next;
  end

endmodule
